@@ design/glpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpc_pkg: shared types and constants of the palette compositor
// Request and result payloads, command and register codes, and the RGB565 to
// RGBA8888 color expansion.
// ----------------------------------------------------------------------------
package glpc_pkg;

  localparam int IDX_W   = 8;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 24;
  localparam int RGBA_W  = 32;
  localparam int PROD_W  = COORD_W + DIM_W;
  localparam int REG_IDX_W = 1;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_DIMENSION_DEF   = 4096;

  localparam logic [DIM_W-1:0] CANVAS_WIDTH_RST  = 13'd320;
  localparam logic [DIM_W-1:0] CANVAS_HEIGHT_RST = 13'd240;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic               command;
    logic [IDX_W-1:0]   color_index;
    logic [COLOR_W-1:0] palette_color;
    logic [COORD_W-1:0] line_x;
    logic [COORD_W-1:0] line_y;
    logic [COORD_W-1:0] pixel_offset;
    logic               restore_background;
    logic               has_transparency;
    logic [IDX_W-1:0]   transparent_index;
    logic [IDX_W-1:0]   background_index;
  } request_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [RGBA_W-1:0] pixel_rgba;
  } result_t;

  // Contents of the lookup stage, handed from the front end to the output stage.
  typedef struct packed {
    logic              valid;
    logic              draw;
    logic              in_range;
    logic [PROD_W-1:0] row_base;
    logic [DIM_W-1:0]  col;
  } lookup_t;

  // Widens 5/6/5 components to 8 bits by repeating their top bits.
  function automatic logic [RGBA_W-1:0] expand565(input logic [COLOR_W-1:0] c);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {ALPHA_OPAQUE, b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
  endfunction

endpackage

@@ design/gif_line_palette_compositor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_line_palette_compositor: palette-indexed pixel to RGBA8888 compositor
// Loads RGB565 palette entries and turns indexed pixels into frame-buffer
// writes with clipping, transparency and background restore.
// ----------------------------------------------------------------------------
// A result passes through the lookup stage register and then the output register.
// Throughput: one request per cycle while out_ready stays high; the palette RAM
// has separate read and write ports, so loads and pixels stream back to back.
// Reset clears the pipeline valid flags and sets the canvas to 320 by 240.
// Palette contents are undefined after reset until each entry is loaded.
module gif_line_palette_compositor #(
  parameter int PALETTE_ENTRIES = glpc_pkg::PALETTE_ENTRIES_DEF,
  parameter int MAX_DIMENSION   = glpc_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [glpc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [glpc_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  glpc_pkg::request_t             in_request,
  output logic                           out_valid,
  input  logic                           out_ready,
  output glpc_pkg::result_t              out_result
);
  import glpc_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [DIM_W-1:0]   canvas_width;
  logic [DIM_W-1:0]   canvas_height;
  lookup_t            stage;
  logic               stage_take;
  logic               pal_wr_en;
  logic [AW-1:0]      pal_wr_addr;
  logic [COLOR_W-1:0] pal_wr_data;
  logic               pal_rd_en;
  logic [AW-1:0]      pal_rd_addr;
  logic [COLOR_W-1:0] pal_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_WIDTH_RST;
      canvas_height <= CANVAS_HEIGHT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  glpc_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .MAX_DIMENSION  (MAX_DIMENSION),
    .AW             (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_request   (in_request),
    .canvas_width (canvas_width),
    .canvas_height(canvas_height),
    .stage_take   (stage_take),
    .stage        (stage),
    .pal_wr_en    (pal_wr_en),
    .pal_wr_addr  (pal_wr_addr),
    .pal_wr_data  (pal_wr_data),
    .pal_rd_en    (pal_rd_en),
    .pal_rd_addr  (pal_rd_addr)
  );

  glpc_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_ENTRIES),
    .AW   (AW)
  ) u_palette (
    .clk    (clk),
    .wr_en  (pal_wr_en),
    .wr_addr(pal_wr_addr),
    .wr_data(pal_wr_data),
    .rd_en  (pal_rd_en),
    .rd_addr(pal_rd_addr),
    .rd_data(pal_rd_data)
  );

  glpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .pal_rd_data(pal_rd_data),
    .stage_take (stage_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

`ifndef ASSERT_OFF
  a_written_opaque: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.write_enable |-> out_result.pixel_rgba[31:24] == ALPHA_OPAQUE)
    else $error("drawn pixel without opaque alpha");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.write_enable |->
      out_result.pixel_address == '0 && out_result.pixel_rgba == '0)
    else $error("non-drawing result carries address or color");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    stage.valid && out_valid && !out_ready |-> !in_ready)
    else $error("request taken while both stages are blocked");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stage.valid)
    else $error("accepted request lost in lookup stage");
`endif

endmodule

@@ design/glpc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpc_ram: generic single-clock RAM
// One write port and one read port with a registered read output.
// ----------------------------------------------------------------------------
module glpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/glpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpc_front: request decode and palette lookup stage
// Writes palette loads, clips pixels, resolves transparency, issues the
// palette read and registers the row product for the output stage.
// ----------------------------------------------------------------------------
module glpc_front #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_DIMENSION   = 4096,
  parameter int AW              = $clog2(PALETTE_ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  glpc_pkg::request_t           in_request,
  input  logic [glpc_pkg::DIM_W-1:0]   canvas_width,
  input  logic [glpc_pkg::DIM_W-1:0]   canvas_height,
  input  logic                         stage_take,
  output glpc_pkg::lookup_t            stage,
  output logic                         pal_wr_en,
  output logic [AW-1:0]                pal_wr_addr,
  output logic [glpc_pkg::COLOR_W-1:0] pal_wr_data,
  output logic                         pal_rd_en,
  output logic [AW-1:0]                pal_rd_addr
);
  import glpc_pkg::*;

  logic              accept;
  logic [DIM_W-1:0]  width_eff;
  logic [DIM_W-1:0]  height_eff;
  logic [DIM_W-1:0]  col;
  logic              clipped;
  logic              is_transparent;
  logic [IDX_W-1:0]  index_eff;
  logic              draw;
  lookup_t           stage_next;

  assign in_ready = !stage.valid || stage_take;
  assign accept   = in_valid && in_ready;

  // Register values above the largest frame dimension act as that dimension.
  assign width_eff  = (32'(canvas_width) > 32'(MAX_DIMENSION)) ?
                      DIM_W'(MAX_DIMENSION) : canvas_width;
  assign height_eff = (32'(canvas_height) > 32'(MAX_DIMENSION)) ?
                      DIM_W'(MAX_DIMENSION) : canvas_height;

  assign col     = DIM_W'(in_request.line_x) + DIM_W'(in_request.pixel_offset);
  assign clipped = (DIM_W'(in_request.line_y) >= height_eff) || (col >= width_eff);

  assign is_transparent = in_request.has_transparency &&
                          (in_request.color_index == in_request.transparent_index);
  assign index_eff      = is_transparent ? in_request.background_index
                                         : in_request.color_index;
  assign draw = (in_request.command == CMD_PIXEL) && !clipped &&
                (!is_transparent || in_request.restore_background);

  assign pal_wr_en   = accept && (in_request.command == CMD_LOAD) &&
                       (32'(in_request.color_index) < 32'(PALETTE_ENTRIES));
  assign pal_wr_addr = in_request.color_index[AW-1:0];
  assign pal_wr_data = in_request.palette_color;
  assign pal_rd_en   = accept && draw;
  assign pal_rd_addr = index_eff[AW-1:0];

  always_comb begin
    stage_next          = stage;
    stage_next.valid    = stage.valid && !stage_take;
    if (accept) begin
      stage_next.valid    = 1'b1;
      stage_next.draw     = draw;
      stage_next.in_range = 32'(index_eff) < 32'(PALETTE_ENTRIES);
      stage_next.row_base = PROD_W'(in_request.line_y) * PROD_W'(width_eff);
      stage_next.col      = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
    stage.draw     <= stage_next.draw;
    stage.in_range <= stage_next.in_range;
    stage.row_base <= stage_next.row_base;
    stage.col      <= stage_next.col;
  end

endmodule

@@ design/glpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpc_back: output stage
// Forms the frame-buffer address and the expanded color and holds the result
// until it is taken.
// ----------------------------------------------------------------------------
module glpc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  glpc_pkg::lookup_t            stage,
  input  logic [glpc_pkg::COLOR_W-1:0] pal_rd_data,
  output logic                         stage_take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output glpc_pkg::result_t            out_result
);
  import glpc_pkg::*;

  logic [COLOR_W-1:0] entry;
  logic [PROD_W-1:0]  addr_sum;
  result_t            result_next;

  assign stage_take = stage.valid && (!out_valid || out_ready);

  // Indexes beyond the palette read as opaque black.
  assign entry    = stage.in_range ? pal_rd_data : '0;
  assign addr_sum = stage.row_base + PROD_W'(stage.col);

  always_comb begin
    result_next = '0;
    if (stage.draw) begin
      result_next.write_enable  = 1'b1;
      result_next.pixel_address = addr_sum[ADDR_W-1:0];
      result_next.pixel_rgba    = expand565(entry);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (stage_take) begin
      out_result <= result_next;
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gif_line_palette_compositor
// A directed table covers palette loads, color extremes, clipping and the
// transparency cases, and then random traffic runs under several canvas
// sizes. Every result is checked against a typed table value or a predictor kept in
// step with the palette and canvas registers, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
  import glpc_pkg::*;

  localparam int unsigned MAX_DIM = MAX_DIMENSION_DEF;
  localparam result_t NO_WRITE = '0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  request_t             in_request = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_result;

  // Shadow copies of the block's state.
  logic [COLOR_W-1:0] palette_shadow [PALETTE_ENTRIES_DEF];
  bit                 entry_loaded [PALETTE_ENTRIES_DEF];
  logic [IDX_W-1:0]   loaded_entries [$];
  logic [DIM_W-1:0]   canvas_w = CANVAS_WIDTH_RST;
  logic [DIM_W-1:0]   canvas_h = CANVAS_HEIGHT_RST;

  result_t  pending_fb_writes [$];
  request_t table_req [$];
  bit       table_typed [$];
  result_t  table_res [$];
  int       mismatches = 0;
  bit       steady = 1'b0;

  int phase_w [8] = '{4096, 1, 0, 8191, 320, 4097, 37, 320};
  int phase_h [8] = '{4096, 1, 240, 8191, 0, 3, 29, 240};

  gif_line_palette_compositor u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_request(in_request),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_result(out_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_cycles();
    if (steady) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Computes the frame-buffer write for one request and applies palette loads.
  function automatic result_t composite_pixel(input request_t r);
    result_t          res;
    int unsigned      w;
    int unsigned      h;
    int unsigned      col;
    int unsigned      row;
    logic [IDX_W-1:0] idx;
    logic [COLOR_W-1:0] c;
    res = NO_WRITE;
    w = (32'(canvas_w) > MAX_DIM) ? MAX_DIM : 32'(canvas_w);
    h = (32'(canvas_h) > MAX_DIM) ? MAX_DIM : 32'(canvas_h);
    if (r.command == CMD_LOAD) begin
      if (!entry_loaded[r.color_index]) begin
        entry_loaded[r.color_index] = 1'b1;
        loaded_entries.push_back(r.color_index);
      end
      palette_shadow[r.color_index] = r.palette_color;
      return res;
    end
    row = 32'(r.line_y);
    col = 32'(r.line_x) + 32'(r.pixel_offset);
    if (row >= h || col >= w) return res;
    idx = r.color_index;
    if (r.has_transparency && idx == r.transparent_index) begin
      if (!r.restore_background) return res;
      idx = r.background_index;
    end
    c = palette_shadow[idx];
    res.write_enable  = 1'b1;
    res.pixel_address = ADDR_W'(row * w + col);
    // Each component repeats its top bits to fill eight; red sits in the low byte.
    res.pixel_rgba = {ALPHA_OPAQUE, c[4:0], c[4:2], c[10:5], c[10:9], c[15:11], c[15:13]};
    return res;
  endfunction

  function automatic request_t mk_req(input logic cmd, input logic [7:0] idx,
                                      input logic [15:0] color, input logic [11:0] lx,
                                      input logic [11:0] ly, input logic [11:0] off,
                                      input logic restore, input logic transp,
                                      input logic [7:0] tidx, input logic [7:0] bidx);
    request_t r;
    r.command            = cmd;
    r.color_index        = idx;
    r.palette_color      = color;
    r.line_x             = lx;
    r.line_y             = ly;
    r.pixel_offset       = off;
    r.restore_background = restore;
    r.has_transparency   = transp;
    r.transparent_index  = tidx;
    r.background_index   = bidx;
    return r;
  endfunction

  task automatic row(input request_t req, input bit typed, input result_t res);
    table_req.push_back(req);
    table_typed.push_back(typed);
    table_res.push_back(res);
  endtask

  // Presents one request and records its expected write once it is taken.
  task automatic send_request(input request_t req, input bit typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_request <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = composite_pixel(req);
    pending_fb_writes.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic set_canvas(input int w, input int h);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_data  <= DIM_W'(w);
    @(negedge clk);
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_data  <= DIM_W'(h);
    @(negedge clk);
    cfg_wen  <= 1'b0;
    canvas_w = DIM_W'(w);
    canvas_h = DIM_W'(h);
  endtask

  task automatic run_random(input int count);
    request_t    req;
    logic [95:0] noise;
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned ypos;
    int unsigned off;
    int unsigned mode;
    w = (32'(canvas_w) > MAX_DIM) ? MAX_DIM : 32'(canvas_w);
    h = (32'(canvas_h) > MAX_DIM) ? MAX_DIM : 32'(canvas_h);
    for (int n = 0; n < count; n++) begin
      noise = {$urandom, $urandom, $urandom};
      req = noise[$bits(request_t)-1:0];
      if ($urandom_range(0, 3) == 0) begin
        req.command = CMD_LOAD;
      end else begin
        // Pixels only ever name palette entries that have been loaded.
        req.command = CMD_PIXEL;
        req.color_index = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
        req.background_index = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
        if ($urandom_range(0, 2) == 0) req.transparent_index = req.color_index;
        mode = $urandom_range(0, 7);
        if (mode <= 5 && w > 0 && h > 0) begin
          if (mode == 5) begin
            ypos = h - 1 + $urandom_range(0, 1);
            col  = w - 1 + $urandom_range(0, 1);
            if (ypos > 4095) ypos = 4095;
          end else begin
            ypos = $urandom_range(0, h - 1);
            col  = $urandom_range(0, w - 1);
          end
          off = $urandom_range(0, (col > 4095) ? 4095 : col);
          req.line_y       = COORD_W'(ypos);
          req.pixel_offset = COORD_W'(off);
          req.line_x       = COORD_W'(col - off);
        end
      end
      send_request(req, 1'b0, NO_WRITE);
    end
  endtask

  initial begin
    row(mk_req(CMD_LOAD, 8'h00, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1, 8'hFF, 8'hFF),
        1'b1, NO_WRITE);
    row(mk_req(CMD_LOAD, 8'hFF, 16'h0000, 12'h000, 12'h000, 12'h000, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_LOAD, 8'h01, 16'hF800, 12'h0, 12'h0, 12'h0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_LOAD, 8'h02, 16'h07E0, 12'h0, 12'h0, 12'h0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_LOAD, 8'h03, 16'h001F, 12'h0, 12'h0, 12'h0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_LOAD, 8'hAA, 16'h5555, 12'hAAA, 12'h555, 12'hAAA, 1'b1, 1'b0, 8'h55, 8'hAA),
        1'b1, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'h00, 16'h0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, {1'b1, 24'd0, 32'hFFFFFFFF});
    row(mk_req(CMD_PIXEL, 8'hFF, 16'h0, 12'd0, 12'd239, 12'd319, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, {1'b1, 24'd76799, 32'hFF000000});
    row(mk_req(CMD_PIXEL, 8'h01, 16'h0, 12'd100, 12'd10, 12'd20, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, {1'b1, 24'd3320, 32'hFF0000FF});
    row(mk_req(CMD_PIXEL, 8'h02, 16'h0, 12'd0, 12'd1, 12'd0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, {1'b1, 24'd320, 32'hFF00FF00});
    row(mk_req(CMD_PIXEL, 8'h03, 16'h0, 12'd5, 12'd0, 12'd0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, {1'b1, 24'd5, 32'hFFFF0000});
    // Clipping on the column, on the column sum and on the row.
    row(mk_req(CMD_PIXEL, 8'h00, 16'h0, 12'd320, 12'd0, 12'd0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'h00, 16'h0, 12'd4095, 12'd0, 12'd4095, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'h00, 16'h0, 12'd0, 12'd240, 12'd0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'h00, 16'h0, 12'd0, 12'd4095, 12'd0, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b1, NO_WRITE);
    // Transparency: skipped, restored, flag off, and an index that does not match.
    row(mk_req(CMD_PIXEL, 8'h01, 16'h0, 12'd7, 12'd7, 12'd0, 1'b0, 1'b1, 8'h01, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'h01, 16'h0, 12'd7, 12'd7, 12'd1, 1'b1, 1'b1, 8'h01, 8'h00),
        1'b0, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'h01, 16'h0, 12'd7, 12'd7, 12'd2, 1'b1, 1'b0, 8'h01, 8'h00),
        1'b0, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'h03, 16'h0, 12'd7, 12'd8, 12'd0, 1'b1, 1'b1, 8'h01, 8'hFF),
        1'b0, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'hAA, 16'h0, 12'd7, 12'd9, 12'd0, 1'b1, 1'b1, 8'hAA, 8'hAA),
        1'b0, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'hAA, 16'hFFFF, 12'd300, 12'd100, 12'd19, 1'b0, 1'b0, 8'h00, 8'h00),
        1'b0, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'h01, 16'h0, 12'd7, 12'd240, 12'd0, 1'b1, 1'b1, 8'h01, 8'h00),
        1'b1, NO_WRITE);
    row(mk_req(CMD_PIXEL, 8'hFF, 16'h0, 12'd300, 12'd239, 12'd19, 1'b1, 1'b1, 8'hFF, 8'h03),
        1'b0, NO_WRITE);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < table_req.size(); i++) begin
      send_request(table_req[i], table_typed[i], table_res[i]);
    end

    // Each canvas setting is written only after the block has drained.
    for (int p = 0; p < 8; p++) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (pending_fb_writes.size() != 0) @(negedge clk);
      set_canvas(phase_w[p], phase_h[p]);
      steady = (p == 2 || p == 5);
      run_random(120);
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_fb_writes.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** gif_line_palette_compositor: PASSED **");
    end else begin
      $display("** gif_line_palette_compositor: FAILED **");
    end
    $finish;
  end

  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_fb_writes.size() == 0) begin
        $error("result with no request outstanding: %h", out_result);
        mismatches++;
      end else begin
        want = pending_fb_writes.pop_front();
        if (out_result.write_enable !== want.write_enable) begin
          $error("write_enable: expected %h, got %h", want.write_enable,
                 out_result.write_enable);
          mismatches++;
        end
        if (out_result.pixel_address !== want.pixel_address) begin
          $error("pixel_address: expected %h, got %h", want.pixel_address,
                 out_result.pixel_address);
          mismatches++;
        end
        if (out_result.pixel_rgba !== want.pixel_rgba) begin
          $error("pixel_rgba: expected %h, got %h", want.pixel_rgba, out_result.pixel_rgba);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("** gif_line_palette_compositor: FAILED **");
    $finish;
  end

endmodule
